>>> design/descending_exchange_sort_index_defines.svh
// Assertion macros shared by the sort index modules.
`ifndef DESCENDING_EXCHANGE_SORT_INDEX_DEFINES_SVH
`define DESCENDING_EXCHANGE_SORT_INDEX_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define DESI_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DESI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/desi_pkg.sv
// Package with the constants, controller states and command/status types.
package desi_pkg;

   localparam int MAX_ROWS       = 64;
   localparam int VALUE_BITS     = 32;
   localparam int SAMPLE_BITS    = 32;
   localparam int ROW_INDEX_BITS = 6;
   localparam int ADDR_BITS      = $clog2(MAX_ROWS);
   localparam int COUNT_BITS     = $clog2(MAX_ROWS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS_SETUP,
      ST_SORT_ISSUE,
      ST_SORT_DRAIN,
      ST_WRITEBACK,
      ST_OUT_ISSUE,
      ST_OUT_DRAIN
   } desi_state_type;

   typedef struct packed {
      logic load;
      logic pass_setup;
      logic out_setup;
      logic issue;
      logic out_mode;
      logic writeback;
      logic run_clear;
   } desi_cmd_type;

   typedef struct packed {
      logic pass_done;
      logic issue_last;
      logic pipe_busy;
   } desi_status_type;

endpackage

>>> design/descending_exchange_sort_index.sv
// Top level of the descending exchange sort index block.
//
//   channel  ports                                     transfer when
//   request  req_sample_value, req_final_sample        start && !busy
//   response rsp_row_index, rsp_sorted_value,
//            rsp_final_result, rsp_overflowed          rsp_valid (one cycle)
//
// Each accepted value is stored as a new row while there is room. After the final value
// the sort runs n-1 passes over the n stored rows; each pass is a setup, one order/value
// memory read per cycle from the pass position to the last row, a drain of the read
// pipeline and a write-back. Readout gives one result per cycle. busy is high from
// the final value until the last result is out. Reset clears the control state and the
// row count. The receiver cannot stall results; start waits only on busy.
module descending_exchange_sort_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [desi_pkg::SAMPLE_BITS-1:0]    req_sample_value,
   input  logic                                req_final_sample,
   output logic                                rsp_valid,
   output logic [desi_pkg::ROW_INDEX_BITS-1:0] rsp_row_index,
   output logic [desi_pkg::SAMPLE_BITS-1:0]    rsp_sorted_value,
   output logic                                rsp_final_result,
   output logic                                rsp_overflowed
);
   import desi_pkg::*;

   desi_cmd_type    cmd;
   desi_status_type status;

   desi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .final_sample (req_final_sample),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   desi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sample_value     (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

>>> design/desi_datapath.sv
// Datapath: value and order memories, read pipeline, compare/swap and result register.
`include "descending_exchange_sort_index_defines.svh"

module desi_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  desi_pkg::desi_cmd_type              cmd,
   output desi_pkg::desi_status_type           status,
   input  logic [desi_pkg::SAMPLE_BITS-1:0]    sample_value,
   output logic                                rsp_valid,
   output logic [desi_pkg::ROW_INDEX_BITS-1:0] rsp_row_index,
   output logic [desi_pkg::SAMPLE_BITS-1:0]    rsp_sorted_value,
   output logic                                rsp_final_result,
   output logic                                rsp_overflowed
);
   import desi_pkg::*;

   logic [VALUE_BITS-1:0] value_mem [MAX_ROWS];
   logic [ADDR_BITS-1:0]  order_mem [MAX_ROWS];

   logic [COUNT_BITS-1:0] count_ff;
   logic                  drop_ff;
   logic [ADDR_BITS-1:0]  pass_ff;
   logic [ADDR_BITS-1:0]  issue_ff;

   // stage 1: order entry read back
   logic                  s1_valid_ff, s1_first_ff, s1_out_ff, s1_last_ff;
   logic [ADDR_BITS-1:0]  s1_pos_ff;
   logic [ADDR_BITS-1:0]  ord_rd_ff;
   // stage 2: value read back
   logic                  s2_valid_ff, s2_first_ff, s2_out_ff, s2_last_ff;
   logic [ADDR_BITS-1:0]  s2_pos_ff;
   logic [ADDR_BITS-1:0]  ord_s2_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   // element held for the current position of the pass
   logic [ADDR_BITS-1:0]  cur_idx_ff;
   logic [VALUE_BITS-1:0] cur_val_ff;

   logic                       rsp_valid_ff, rsp_final_ff, rsp_over_ff;
   logic [ADDR_BITS-1:0]       rsp_row_ff;
   logic [VALUE_BITS-1:0]      rsp_value_ff;

   logic                  has_room;
   logic                  compare_en;
   logic                  swap;
   logic                  ord_we;
   logic [ADDR_BITS-1:0]  ord_waddr;
   logic [ADDR_BITS-1:0]  ord_wdata;
   logic [ADDR_BITS-1:0]  load_addr;

   assign has_room   = count_ff < COUNT_BITS'(MAX_ROWS);
   assign load_addr  = count_ff[ADDR_BITS-1:0];
   assign compare_en = s2_valid_ff && !s2_out_ff && !s2_first_ff;
   assign swap       = compare_en && ($signed(cur_val_ff) < $signed(val_rd_ff));

   always_comb begin
      ord_we    = 1'b0;
      ord_waddr = load_addr;
      ord_wdata = load_addr;
      if (cmd.load && has_room) begin
         // identity entry for each loaded row
         ord_we = 1'b1;
      end else if (swap) begin
         ord_we    = 1'b1;
         ord_waddr = s2_pos_ff;
         ord_wdata = cur_idx_ff;
      end else if (cmd.writeback) begin
         ord_we    = 1'b1;
         ord_waddr = pass_ff;
         ord_wdata = cur_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         value_mem[load_addr] <= VALUE_BITS'(signed'(sample_value));
      end
      val_rd_ff <= value_mem[ord_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= order_mem[issue_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         pass_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.run_clear) begin
            count_ff <= '0;
            drop_ff  <= 1'b0;
            pass_ff  <= '0;
         end else if (cmd.load) begin
            if (has_room) begin
               count_ff <= count_ff + COUNT_BITS'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end else if (cmd.writeback) begin
            pass_ff <= pass_ff + ADDR_BITS'(1);
         end
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_setup) begin
         issue_ff <= pass_ff;
      end else if (cmd.out_setup) begin
         issue_ff <= '0;
      end else if (cmd.issue) begin
         issue_ff <= issue_ff + ADDR_BITS'(1);
      end

      s1_first_ff <= !cmd.out_mode && (issue_ff == pass_ff);
      s1_out_ff   <= cmd.out_mode;
      s1_last_ff  <= status.issue_last;
      s1_pos_ff   <= issue_ff;

      s2_first_ff <= s1_first_ff;
      s2_out_ff   <= s1_out_ff;
      s2_last_ff  <= s1_last_ff;
      s2_pos_ff   <= s1_pos_ff;
      ord_s2_ff   <= ord_rd_ff;

      // take the first element of the pass, or trade it for a larger one
      if ((s2_valid_ff && !s2_out_ff && s2_first_ff) || swap) begin
         cur_idx_ff <= ord_s2_ff;
         cur_val_ff <= val_rd_ff;
      end

      rsp_row_ff   <= ord_s2_ff;
      rsp_value_ff <= val_rd_ff;
      rsp_final_ff <= s2_last_ff;
      rsp_over_ff  <= drop_ff;
   end

   assign status.pass_done  = (COUNT_BITS'(pass_ff) + COUNT_BITS'(1)) >= count_ff;
   assign status.issue_last = COUNT_BITS'(issue_ff) == (count_ff - COUNT_BITS'(1));
   assign status.pipe_busy  = s1_valid_ff || s2_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = ROW_INDEX_BITS'(rsp_row_ff);
   assign rsp_sorted_value = SAMPLE_BITS'(rsp_value_ff);
   assign rsp_final_result = rsp_final_ff;
   assign rsp_overflowed   = rsp_over_ff;

   `DESI_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_BITS'(MAX_ROWS), "row count above capacity")
   `DESI_ASSERT_IMPLY(a_issue_in_range, clock, reset, cmd.issue, COUNT_BITS'(issue_ff) < count_ff, "read beyond loaded rows")
   `DESI_ASSERT_IMPLY(a_final_drains, clock, reset, rsp_valid_ff && rsp_final_ff, !s2_valid_ff && !s1_valid_ff, "transfer after final result")

endmodule

>>> design/desi_ctrl.sv
// Controller: sequences load, sort passes and result readout.
`include "descending_exchange_sort_index_defines.svh"

module desi_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      final_sample,
   input  desi_pkg::desi_status_type status,
   output desi_pkg::desi_cmd_type    cmd,
   output logic                      busy
);
   import desi_pkg::*;

   desi_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (final_sample) begin
                  state_in = ST_PASS_SETUP;
               end
            end
         end
         ST_PASS_SETUP: begin
            if (status.pass_done) begin
               cmd.out_setup = 1'b1;
               state_in      = ST_OUT_ISSUE;
            end else begin
               cmd.pass_setup = 1'b1;
               state_in       = ST_SORT_ISSUE;
            end
         end
         ST_SORT_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_SORT_DRAIN;
            end
         end
         ST_SORT_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_WRITEBACK;
            end
         end
         ST_WRITEBACK: begin
            // park the held element at the pass position
            cmd.writeback = 1'b1;
            state_in      = ST_PASS_SETUP;
         end
         ST_OUT_ISSUE: begin
            cmd.issue    = 1'b1;
            cmd.out_mode = 1'b1;
            if (status.issue_last) begin
               state_in = ST_OUT_DRAIN;
            end
         end
         ST_OUT_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.run_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   `DESI_ASSERT_IMPLY(a_idle_quiet, clock, reset, state_ff == ST_IDLE, !status.pipe_busy, "pipeline active while idle")

endmodule

>>> tb/desi_result_checker.sv
// Checker for the descending sort index block: predicts sorted columns and compares results.
`timescale 1ns / 100ps

module desi_result_checker
   import desi_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [SAMPLE_BITS-1:0]    req_sample_value,
   input  logic                      req_final_sample,
   input  logic                      rsp_valid,
   input  logic [ROW_INDEX_BITS-1:0] rsp_row_index,
   input  logic [SAMPLE_BITS-1:0]    rsp_sorted_value,
   input  logic                      rsp_final_result,
   input  logic                      rsp_overflowed,
   output int                        outstanding,
   output int                        failures
);

   typedef struct packed {
      logic [ROW_INDEX_BITS-1:0] row;
      logic [SAMPLE_BITS-1:0]    value;
      logic                      last;
      logic                      dropped;
   } sorted_entry_t;

   logic signed [VALUE_BITS-1:0] column_values [MAX_ROWS];
   logic [ROW_INDEX_BITS-1:0]    rank [MAX_ROWS];
   logic [ROW_INDEX_BITS-1:0]    swap_row;
   int                           column_count;
   bit                           column_dropped;
   sorted_entry_t                sorted_rows [$];
   sorted_entry_t                due;
   int                           i;
   int                           j;

   initial begin
      outstanding = 0;
      failures = 0;
      column_count = 0;
      column_dropped = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         column_count = 0;
         column_dropped = 0;
      end else begin
         if (rsp_valid) begin
            if (sorted_rows.size() == 0) begin
               $error("unexpected result: row_index %0d, sorted_value %0h",
                      rsp_row_index, rsp_sorted_value);
               failures++;
            end else begin
               due = sorted_rows.pop_front();
               if (rsp_row_index !== due.row) begin
                  $error("row_index: expected %0d, actual %0d", due.row, rsp_row_index);
                  failures++;
               end
               if (rsp_sorted_value !== due.value) begin
                  $error("sorted_value: expected %0h, actual %0h", due.value,
                         rsp_sorted_value);
                  failures++;
               end
               if (rsp_final_result !== due.last) begin
                  $error("final_result: expected %0b, actual %0b", due.last,
                         rsp_final_result);
                  failures++;
               end
               if (rsp_overflowed !== due.dropped) begin
                  $error("overflowed: expected %0b, actual %0b", due.dropped,
                         rsp_overflowed);
                  failures++;
               end
            end
         end

         if (start && !busy) begin
            // store while there is room, otherwise drop and flag
            if (column_count < MAX_ROWS) begin
               column_values[column_count] = req_sample_value[VALUE_BITS-1:0];
               column_count++;
            end else begin
               column_dropped = 1;
            end

            if (req_final_sample) begin
               for (i = 0; i < column_count; i++)
                  rank[i] = ROW_INDEX_BITS'(i);
               // plain exchange sort, swap whenever the upper entry is larger
               for (i = 0; i < column_count; i++) begin
                  for (j = i + 1; j < column_count; j++) begin
                     if (column_values[rank[i]] < column_values[rank[j]]) begin
                        swap_row = rank[i];
                        rank[i] = rank[j];
                        rank[j] = swap_row;
                     end
                  end
               end
               for (i = 0; i < column_count; i++)
                  sorted_rows.push_back('{row: rank[i],
                                          value: SAMPLE_BITS'(column_values[rank[i]]),
                                          last: (i == column_count - 1),
                                          dropped: column_dropped});
               column_count = 0;
               column_dropped = 0;
            end
         end
      end
      outstanding <= sorted_rows.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top for the descending sort index block: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb;
   import desi_pkg::*;

   localparam int TOTAL_SAMPLES = 430;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic [SAMPLE_BITS-1:0]    req_sample_value = '0;
   logic                      req_final_sample = 1'b0;
   logic                      busy;
   logic                      rsp_valid;
   logic [ROW_INDEX_BITS-1:0] rsp_row_index;
   logic [SAMPLE_BITS-1:0]    rsp_sorted_value;
   logic                      rsp_final_result;
   logic                      rsp_overflowed;
   int                        outstanding;
   int                        failures;
   int                        sent_count = 0;
   int                        column_length;
   int                        pick;
   int                        k;

   always #5 clock = ~clock;

   descending_exchange_sort_index uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_value (req_sample_value),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   desi_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_value (req_sample_value),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed),
      .outstanding      (outstanding),
      .failures         (failures)
   );

   // half full-range values, the rest extremes and a narrow band that forces ties
   function automatic logic [SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
         default: return $urandom();
      endcase
   endfunction

   // idle each cycle with a fixed chance; no idling in the middle stretch of the run
   function automatic int draw_gap();
      int gap;
      gap = 0;
      if (sent_count >= 150 && sent_count < 260)
         return 0;
      while ($urandom_range(0, 99) < 23)
         gap++;
      return gap;
   endfunction

   // called at a rising edge; returns at the edge that completes the transfer
   task automatic transfer_sample(input logic [SAMPLE_BITS-1:0] value, input bit last,
                                  input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_sample_value <= value;
      req_final_sample <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_column(input int length);
      int n;
      for (n = 0; n < length; n++)
         transfer_sample(draw_sample(), n == length - 1, draw_gap());
   endtask

   // hold off the sender until every predicted row has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("descending_exchange_sort_index: mismatch");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-row column
      transfer_sample(32'h7FFF_FFFF, 1'b1, 0);
      // extremes and sign boundaries
      transfer_sample(32'h0000_0000, 1'b0, 0);
      transfer_sample(32'h7FFF_FFFF, 1'b0, 1);
      transfer_sample(32'h8000_0000, 1'b0, 0);
      transfer_sample(32'hFFFF_FFFF, 1'b0, 2);
      transfer_sample(32'h0000_0001, 1'b0, 0);
      transfer_sample(32'h8000_0000, 1'b0, 0);
      transfer_sample(32'h7FFF_FFFF, 1'b0, 0);
      transfer_sample(32'h5A5A_A5A5, 1'b1, 0);
      // ties within a positive and a negative group
      transfer_sample(32'd5, 1'b0, 0);
      transfer_sample(32'd5, 1'b0, 0);
      transfer_sample(-32'sd3, 1'b0, 0);
      transfer_sample(32'd5, 1'b0, 3);
      transfer_sample(-32'sd3, 1'b0, 0);
      transfer_sample(32'd5, 1'b1, 0);
      // all equal
      transfer_sample(32'd0, 1'b0, 0);
      transfer_sample(32'd0, 1'b0, 0);
      transfer_sample(32'd0, 1'b1, 0);
      // already descending
      transfer_sample(32'd3, 1'b0, 0);
      transfer_sample(32'd2, 1'b0, 0);
      transfer_sample(32'd1, 1'b0, 0);
      transfer_sample(32'd0, 1'b1, 0);
      drain_results();

      // full column, then one where the last two samples are dropped
      send_column(MAX_ROWS);
      send_column(MAX_ROWS + 2);
      drain_results();

      k = 0;
      while (sent_count < TOTAL_SAMPLES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            column_length = $urandom_range(1, 12);
         else if (pick < 85)
            column_length = $urandom_range(13, 40);
         else if (pick < 93)
            column_length = MAX_ROWS;
         else
            column_length = $urandom_range(MAX_ROWS + 1, MAX_ROWS + 4);
         send_column(column_length);
         k++;
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("descending_exchange_sort_index: match");
      else
         $display("descending_exchange_sort_index: mismatch");
      $finish;
   end

endmodule
